>>> design/ptta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_pkg
// Shared types and constants for the two-level threshold alarm: field widths,
// register indexes, event levels and the event bundle passed through the queue.
// ----------------------------------------------------------------------------
package ptta_pkg;

	localparam int NUM_METRICS     = 3;
	localparam int VAL_W           = 14;
	localparam int PERSIST_W       = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int RUN_COUNT_WIDTH = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CPU_WARN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CPU_CRIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_WARN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_CRIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_WARN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DISK_CRIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERSIST   = 3'd6;

	localparam logic [VAL_W-1:0]     WARN_RESET    = 14'd8000;
	localparam logic [VAL_W-1:0]     CRIT_RESET    = 14'd9000;
	localparam logic [PERSIST_W-1:0] PERSIST_RESET = 8'd3;

	typedef enum logic [1:0] {
		LVL_INFO     = 2'd0,
		LVL_WARNING  = 2'd1,
		LVL_CRITICAL = 2'd2
	} level_t;

	typedef struct packed {
		logic [1:0]       metric_id;
		level_t           level;
		logic             is_recovery;
		logic             is_upgrade;
		logic [VAL_W-1:0] sample_value;
		logic [VAL_W-1:0] crossed_level;
	} event_t;

	typedef struct packed {
		logic [NUM_METRICS-1:0] valid;
		event_t [NUM_METRICS-1:0] ev;
	} bundle_t;

	typedef struct packed {
		logic [NUM_METRICS-1:0][VAL_W-1:0] warn;
		logic [NUM_METRICS-1:0][VAL_W-1:0] crit;
		logic [PERSIST_W-1:0]              persist;
	} cfg_t;

endpackage

>>> design/ptta_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_front
// Accepts samples, classifies each metric, updates run and alarm state and
// pushes a bundle of up to three events into the queue.
// ----------------------------------------------------------------------------
module ptta_front #(
	parameter int RUN_COUNT_WIDTH = ptta_pkg::RUN_COUNT_WIDTH
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 in_valid,
	output logic                                                 in_ready,
	input  logic [ptta_pkg::NUM_METRICS-1:0][ptta_pkg::VAL_W-1:0] sample,
	input  ptta_pkg::cfg_t                                       cfg,
	input  logic                                                 queue_full,
	output logic                                                 push,
	output ptta_pkg::bundle_t                                    push_data
);

	localparam int CW = (RUN_COUNT_WIDTH > ptta_pkg::PERSIST_W) ?
		RUN_COUNT_WIDTH : ptta_pkg::PERSIST_W;
	localparam logic [RUN_COUNT_WIDTH-1:0] RUN_MAX = '1;

	logic [RUN_COUNT_WIDTH-1:0] run_q  [ptta_pkg::NUM_METRICS];
	logic [RUN_COUNT_WIDTH-1:0] run_d  [ptta_pkg::NUM_METRICS];
	logic [ptta_pkg::NUM_METRICS-1:0] alarm_q, alarm_d;
	logic [ptta_pkg::NUM_METRICS-1:0] crit_q, crit_d;
	logic accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		logic [ptta_pkg::VAL_W-1:0]  v;
		logic                        is_crit;
		logic                        is_warn;
		logic [RUN_COUNT_WIDTH-1:0]  run_inc;
		push_data = '0;
		for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
			v       = sample[m];
			is_crit = v >= cfg.crit[m];
			is_warn = !is_crit && (v >= cfg.warn[m]);
			run_inc = (run_q[m] == RUN_MAX) ? run_q[m] : run_q[m] + 1'b1;
			run_d[m]   = run_q[m];
			alarm_d[m] = alarm_q[m];
			crit_d[m]  = crit_q[m];
			push_data.ev[m].metric_id    = 2'(m);
			push_data.ev[m].sample_value = v;
			if (is_crit || is_warn) begin
				run_d[m] = run_inc;
				push_data.ev[m].crossed_level = is_crit ? cfg.crit[m] : cfg.warn[m];
				if (alarm_q[m]) begin
					if (!crit_q[m] && is_crit) begin
						push_data.valid[m]         = 1'b1;
						push_data.ev[m].level      = ptta_pkg::LVL_CRITICAL;
						push_data.ev[m].is_upgrade = 1'b1;
						crit_d[m]                  = 1'b1;
					end
				end else if (CW'(run_inc) >= CW'(cfg.persist)) begin
					push_data.valid[m]    = 1'b1;
					push_data.ev[m].level = is_crit ? ptta_pkg::LVL_CRITICAL :
						ptta_pkg::LVL_WARNING;
					alarm_d[m]            = 1'b1;
					crit_d[m]             = is_crit;
				end
			end else begin
				run_d[m] = '0;
				push_data.ev[m].crossed_level = cfg.warn[m];
				if (alarm_q[m]) begin
					push_data.valid[m]          = 1'b1;
					push_data.ev[m].level       = ptta_pkg::LVL_INFO;
					push_data.ev[m].is_recovery = 1'b1;
					alarm_d[m]                  = 1'b0;
					crit_d[m]                   = 1'b0;
				end
			end
		end
	end

	assign push = accept && (|push_data.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
				run_q[m] <= '0;
			end
			alarm_q <= '0;
			crit_q  <= '0;
		end else if (accept) begin
			for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
				run_q[m] <= run_d[m];
			end
			alarm_q <= alarm_d;
			crit_q  <= crit_d;
		end
	end

endmodule

>>> design/ptta_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_queue
// Short bundle queue between the classifier and the event serializer.
// ----------------------------------------------------------------------------
module ptta_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptta_pkg::bundle_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output ptta_pkg::bundle_t head
);

	localparam int PW = ptta_pkg::QUEUE_PTR_W;
	localparam int CNTW = ptta_pkg::QUEUE_CNT_W;
	localparam logic [PW-1:0]   PTR_LAST = PW'(ptta_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNTW-1:0] CNT_FULL = CNTW'(ptta_pkg::QUEUE_DEPTH);

	ptta_pkg::bundle_t mem_q [ptta_pkg::QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]   cnt_q;
	logic              do_push, do_pop;

	assign full       = cnt_q == CNT_FULL;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/ptta_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptta_back
// Takes event bundles from the queue and emits their events one per cycle
// while the output is not stalled, in metric order, through an output register.
// ----------------------------------------------------------------------------
module ptta_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  ptta_pkg::bundle_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output ptta_pkg::event_t  out_ev,
	output logic              out_last
);

	localparam int NM = ptta_pkg::NUM_METRICS;

	logic [ptta_pkg::NUM_METRICS-1:0] work_mask_q;
	ptta_pkg::event_t [ptta_pkg::NUM_METRICS-1:0] work_ev_q;
	logic [ptta_pkg::NUM_METRICS-1:0] sel_onehot, rest;
	logic [1:0] sel;
	logic take, emit;

	always_comb begin
		if (work_mask_q[0]) begin
			sel = 2'd0;
		end else if (work_mask_q[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign sel_onehot = NM'(1) << sel;
	assign rest       = work_mask_q & ~sel_onehot;
	assign take       = !out_valid || out_ready;
	assign emit       = take && (|work_mask_q);
	assign pop        = head_valid && ((work_mask_q == '0) || (emit && (rest == '0)));

	always_ff @(posedge clk) begin
		if (pop) begin
			work_ev_q <= head.ev;
		end
		if (emit) begin
			out_ev   <= work_ev_q[sel];
			out_last <= rest == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_mask_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (pop) begin
				work_mask_q <= head.valid;
			end else if (emit) begin
				work_mask_q <= rest;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> design/persistent_two_level_threshold_alarm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// persistent_two_level_threshold_alarm_top
// Path: a sample's events pass through the bundle queue, the serializer work
// register and the output register. Throughput: one sample per cycle while the
// two-entry bundle queue has room; the event serializer drains one event per
// cycle while out_ready allows, and a sample causes zero to three events.
// Reset: run counts and alarm flags clear, thresholds return to 8000 and 9000,
// persistence count to 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
module persistent_two_level_threshold_alarm_top #(
	parameter int RUN_COUNT_WIDTH = ptta_pkg::RUN_COUNT_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ptta_pkg::VAL_W-1:0]      cpu_sample,
	input  logic [ptta_pkg::VAL_W-1:0]      mem_sample,
	input  logic [ptta_pkg::VAL_W-1:0]      disk_sample,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ptta_pkg::VAL_W-1:0]      cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      metric_id,
	output logic [1:0]                      event_level,
	output logic                            is_recovery,
	output logic                            is_upgrade,
	output logic [ptta_pkg::VAL_W-1:0]      sample_value,
	output logic [ptta_pkg::VAL_W-1:0]      crossed_level,
	output logic                            last_event
);

	ptta_pkg::cfg_t    cfg_q;
	ptta_pkg::bundle_t push_data, head;
	ptta_pkg::event_t  out_ev;
	logic [ptta_pkg::NUM_METRICS-1:0][ptta_pkg::VAL_W-1:0] sample;
	logic push, queue_full, pop, head_valid;

	assign cfg_ready = 1'b1;
	assign sample[0] = cpu_sample;
	assign sample[1] = mem_sample;
	assign sample[2] = disk_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
				cfg_q.warn[m] <= ptta_pkg::WARN_RESET;
				cfg_q.crit[m] <= ptta_pkg::CRIT_RESET;
			end
			cfg_q.persist <= ptta_pkg::PERSIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptta_pkg::REG_CPU_WARN:  cfg_q.warn[0] <= cfg_data;
				ptta_pkg::REG_CPU_CRIT:  cfg_q.crit[0] <= cfg_data;
				ptta_pkg::REG_MEM_WARN:  cfg_q.warn[1] <= cfg_data;
				ptta_pkg::REG_MEM_CRIT:  cfg_q.crit[1] <= cfg_data;
				ptta_pkg::REG_DISK_WARN: cfg_q.warn[2] <= cfg_data;
				ptta_pkg::REG_DISK_CRIT: cfg_q.crit[2] <= cfg_data;
				ptta_pkg::REG_PERSIST:   cfg_q.persist <= cfg_data[ptta_pkg::PERSIST_W-1:0];
				default: ;
			endcase
		end
	end

	ptta_front #(
		.RUN_COUNT_WIDTH(RUN_COUNT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.cfg       (cfg_q),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	ptta_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	ptta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_ev    (out_ev),
		.out_last  (last_event)
	);

	assign metric_id     = out_ev.metric_id;
	assign event_level   = out_ev.level;
	assign is_recovery   = out_ev.is_recovery;
	assign is_upgrade    = out_ev.is_upgrade;
	assign sample_value  = out_ev.sample_value;
	assign crossed_level = out_ev.crossed_level;

endmodule

>>> test/persistent_two_level_threshold_alarm_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// persistent_two_level_threshold_alarm_top_test
// Drives CPU, memory and disk samples into the alarm block and checks every
// event against a local model of the run counters and alarm flags. It covers
// the reset thresholds, persistence extremes, threshold corner cases and
// randomized phases, with random input bursts and output stalls.
// ----------------------------------------------------------------------------
module persistent_two_level_threshold_alarm_top_test;

	typedef logic [ptta_pkg::VAL_W-1:0] val_t;

	localparam val_t VAL_MAX = '1;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_LIMIT = 100;
	localparam logic [ptta_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic [1:0]         metric;
		ptta_pkg::level_t   level;
		logic               recovery;
		logic               upgrade;
		val_t               value;
		val_t               threshold;
		logic               last;
	} alarm_event_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	val_t                           cpu_sample;
	val_t                           mem_sample;
	val_t                           disk_sample;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ptta_pkg::CFG_IDX_W-1:0] cfg_index;
	val_t                           cfg_data;
	logic                           out_valid;
	logic                           out_ready;
	logic [1:0]                     metric_id;
	logic [1:0]                     event_level;
	logic                           is_recovery;
	logic                           is_upgrade;
	val_t                           sample_value;
	val_t                           crossed_level;
	logic                           last_event;

	val_t                                 warn_thr [ptta_pkg::NUM_METRICS];
	val_t                                 crit_thr [ptta_pkg::NUM_METRICS];
	logic [ptta_pkg::PERSIST_W-1:0]       persist_len;
	logic [ptta_pkg::RUN_COUNT_WIDTH-1:0] run_len [ptta_pkg::NUM_METRICS];
	logic                                 alarm_on [ptta_pkg::NUM_METRICS];
	logic                                 alarm_crit [ptta_pkg::NUM_METRICS];

	alarm_event_t pending_events [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int burst_left = 0;

	persistent_two_level_threshold_alarm_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cpu_sample    (cpu_sample),
		.mem_sample    (mem_sample),
		.disk_sample   (disk_sample),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.metric_id     (metric_id),
		.event_level   (event_level),
		.is_recovery   (is_recovery),
		.is_upgrade    (is_upgrade),
		.sample_value  (sample_value),
		.crossed_level (crossed_level),
		.last_event    (last_event)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic alarm_event_t make_event(input int m, input ptta_pkg::level_t lvl,
			input logic rec, input logic upg, input val_t val, input val_t thr);
		alarm_event_t ev;
		ev.metric = 2'(m);
		ev.level = lvl;
		ev.recovery = rec;
		ev.upgrade = upg;
		ev.value = val;
		ev.threshold = thr;
		ev.last = 1'b0;
		return ev;
	endfunction

	function automatic void predict_events(
			input logic [ptta_pkg::NUM_METRICS-1:0][ptta_pkg::VAL_W-1:0] smp);
		alarm_event_t fresh [$];
		logic crit_hit;
		logic warn_hit;
		val_t thr;
		for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
			crit_hit = smp[m] >= crit_thr[m];
			warn_hit = !crit_hit && smp[m] >= warn_thr[m];
			thr = crit_hit ? crit_thr[m] : warn_thr[m];
			if (crit_hit || warn_hit) begin
				if (run_len[m] != '1)
					run_len[m]++;
				if (alarm_on[m]) begin
					if (!alarm_crit[m] && crit_hit) begin
						fresh.insert(fresh.size(), make_event(m, ptta_pkg::LVL_CRITICAL,
							1'b0, 1'b1, smp[m], thr));
						alarm_crit[m] = 1'b1;
					end
				end else if (run_len[m] >= persist_len) begin
					fresh.insert(fresh.size(), make_event(m,
						crit_hit ? ptta_pkg::LVL_CRITICAL : ptta_pkg::LVL_WARNING,
						1'b0, 1'b0, smp[m], thr));
					alarm_on[m] = 1'b1;
					alarm_crit[m] = crit_hit;
				end
			end else begin
				run_len[m] = '0;
				if (alarm_on[m]) begin
					fresh.insert(fresh.size(), make_event(m, ptta_pkg::LVL_INFO,
						1'b1, 1'b0, smp[m], warn_thr[m]));
					alarm_on[m] = 1'b0;
					alarm_crit[m] = 1'b0;
				end
			end
		end
		if (fresh.size() != 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			pending_events.insert(pending_events.size(), fresh[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// transaction send: bursts of random length, random gaps between bursts
	task automatic send_sample(input val_t c, input val_t m, input val_t d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cpu_sample <= c;
		mem_sample <= m;
		disk_sample <= d;
		do @(posedge clk); while (!in_ready);
		predict_events({d, m, c});
	endtask

	task automatic write_reg(input logic [ptta_pkg::CFG_IDX_W-1:0] idx, input val_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ptta_pkg::REG_CPU_WARN:  warn_thr[0] = data;
			ptta_pkg::REG_CPU_CRIT:  crit_thr[0] = data;
			ptta_pkg::REG_MEM_WARN:  warn_thr[1] = data;
			ptta_pkg::REG_MEM_CRIT:  crit_thr[1] = data;
			ptta_pkg::REG_DISK_WARN: warn_thr[2] = data;
			ptta_pkg::REG_DISK_CRIT: crit_thr[2] = data;
			ptta_pkg::REG_PERSIST:   persist_len = data[ptta_pkg::PERSIST_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid, wait out every expected event, then let silent samples finish
	task automatic drain_events();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_metric(input int m, input val_t warn, input val_t crit);
		case (m)
			0: begin
				write_reg(ptta_pkg::REG_CPU_WARN, warn);
				write_reg(ptta_pkg::REG_CPU_CRIT, crit);
			end
			1: begin
				write_reg(ptta_pkg::REG_MEM_WARN, warn);
				write_reg(ptta_pkg::REG_MEM_CRIT, crit);
			end
			default: begin
				write_reg(ptta_pkg::REG_DISK_WARN, warn);
				write_reg(ptta_pkg::REG_DISK_CRIT, crit);
			end
		endcase
	endtask

	task automatic test_default_levels();
		send_sample(0, 0, 0);
		repeat (3) send_sample(8000, 9000, VAL_MAX);
		send_sample(9000, 9000, 8999);
		send_sample(8500, 8000, 9000);
		send_sample(9500, 9999, 10000);
		send_sample(7999, 0, 16383);
		send_sample(0, 0, 0);
		repeat (2) send_sample(8000, 8000, 0);
		send_sample(0, 8000, 0);
		repeat (2) send_sample(8000, 9000, 8000);
		send_sample(0, 0, 0);
		drain_events();
	endtask

	task automatic test_persistence();
		write_reg(ptta_pkg::REG_PERSIST, 14'd0);
		send_sample(9000, 0, 0);
		send_sample(0, 0, 8000);
		send_sample(0, 0, 0);
		drain_events();
		write_reg(ptta_pkg::REG_PERSIST, 14'h3F01);
		send_sample(0, 8000, 0);
		send_sample(0, 0, 0);
		drain_events();
		// hold abnormal below the persistence count
		write_reg(ptta_pkg::REG_PERSIST, 14'd255);
		repeat (8) send_sample(9500, 8500, 12000);
		send_sample(0, 0, 0);
		drain_events();
	endtask

	task automatic test_threshold_edges();
		write_metric(0, 14'd5000, 14'd1000);
		write_metric(1, 14'd0, 14'd0);
		write_metric(2, VAL_MAX, VAL_MAX);
		write_reg(ptta_pkg::REG_PERSIST, 14'd1);
		send_sample(2000, 0, 16382);
		send_sample(999, VAL_MAX, VAL_MAX);
		send_sample(VAL_MAX, 10000, 0);
		send_sample(4999, 0, 10000);
		drain_events();
		write_reg(REG_UNUSED, 14'h3FFF);
		write_metric(0, 14'd10000, 14'd10000);
		send_sample(10000, 0, 0);
		send_sample(9999, 0, VAL_MAX);
		send_sample(0, 0, 0);
		drain_events();
	endtask

	function automatic val_t pick_level();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 14'd10000;
			2: return VAL_MAX;
			default: return val_t'($urandom_range(1000, 9500));
		endcase
	endfunction

	function automatic val_t pick_sample(input int m, input int band);
		val_t floor_thr;
		floor_thr = (warn_thr[m] < crit_thr[m]) ? warn_thr[m] : crit_thr[m];
		case (band)
			0: return (floor_thr == 0) ? val_t'($urandom_range(0, VAL_MAX)) :
				val_t'($urandom_range(0, floor_thr - 1));
			1: return (warn_thr[m] < crit_thr[m]) ?
				val_t'($urandom_range(warn_thr[m], crit_thr[m] - 1)) :
				val_t'($urandom_range(0, VAL_MAX));
			default: return val_t'($urandom_range(crit_thr[m], VAL_MAX));
		endcase
	endfunction

	task automatic test_random_phases();
		val_t warn;
		val_t crit;
		val_t tmp;
		val_t persist;
		logic [ptta_pkg::NUM_METRICS-1:0][ptta_pkg::VAL_W-1:0] smp;
		int band [ptta_pkg::NUM_METRICS];
		int band_left [ptta_pkg::NUM_METRICS];
		for (int phase = 0; phase < 6; phase++) begin
			for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
				warn = pick_level();
				crit = pick_level();
				if ($urandom_range(0, 3) != 0 && warn > crit) begin
					tmp = warn;
					warn = crit;
					crit = tmp;
				end
				write_metric(m, warn, crit);
				band_left[m] = 0;
			end
			case ($urandom_range(0, 9))
				0: persist = 14'd0;
				1: persist = 14'd255;
				2: persist = {6'($urandom_range(0, 63)), 8'($urandom_range(1, 4))};
				default: persist = val_t'($urandom_range(1, 4));
			endcase
			write_reg(ptta_pkg::REG_PERSIST, persist);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_UNUSED, val_t'($urandom_range(0, VAL_MAX)));
			for (int i = 0; i < 24; i++) begin
				for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
					if (band_left[m] == 0) begin
						band[m] = $urandom_range(0, 2);
						band_left[m] = $urandom_range(1, 8);
					end
					band_left[m]--;
					smp[m] = ($urandom_range(0, 9) == 0) ? val_t'($urandom_range(0, VAL_MAX)) :
						pick_sample(m, band[m]);
				end
				send_sample(smp[0], smp[1], smp[2]);
			end
			drain_events();
		end
	endtask

	// output side: check each transaction, stall on a changing pattern
	initial begin
		int ready_mode;
		int mode_left;
		int tick;
		alarm_event_t want;
		ready_mode = 0;
		mode_left = 0;
		tick = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (arst_n && out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event metric %0d level %0d value %0d",
						metric_id, event_level, sample_value));
				end else begin
					want = pending_events.pop_front();
					check_field("metric_id", 16'(metric_id), 16'(want.metric));
					check_field("event_level", 16'(event_level), 16'(want.level));
					check_field("is_recovery", 16'(is_recovery), 16'(want.recovery));
					check_field("is_upgrade", 16'(is_upgrade), 16'(want.upgrade));
					check_field("sample_value", 16'(sample_value), 16'(want.value));
					check_field("crossed_level", 16'(crossed_level), 16'(want.threshold));
					check_field("last_event", 16'(last_event), 16'(want.last));
				end
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (tick % 3) != 0;
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cpu_sample <= '0;
		mem_sample <= '0;
		disk_sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= ptta_pkg::REG_CPU_WARN;
		cfg_data <= '0;
		for (int m = 0; m < ptta_pkg::NUM_METRICS; m++) begin
			warn_thr[m] = ptta_pkg::WARN_RESET;
			crit_thr[m] = ptta_pkg::CRIT_RESET;
			run_len[m] = '0;
			alarm_on[m] = 1'b0;
			alarm_crit[m] = 1'b0;
		end
		persist_len = ptta_pkg::PERSIST_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_levels();
		test_persistence();
		test_threshold_edges();
		test_random_phases();
		drain_events();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
